// File: hw/rtl/imu_cal_pkg.sv
// shared types, constants and codes for the imu bias calibration and scaling block
package imu_cal_pkg;

    // fixed formats
    localparam int RAW_W              = 16;
    localparam int SCALE_W            = 24;
    localparam int COUNT_W            = 16;
    localparam int SUM_W              = 32;
    localparam int OUT_W              = 32;
    localparam int SCALE_FRAC         = 24;
    localparam int OUT_FRAC           = 16;
    localparam int BIAS_FRAC_BITS_DEF = 8;

    // result lanes of the shared multiplier
    localparam int N_AXES  = 3;
    localparam int N_LANES = 6;
    localparam int LANE_W  = 3;
    localparam logic [LANE_W-1:0] LANE_GX = 3'd0;
    localparam logic [LANE_W-1:0] LANE_GY = 3'd1;
    localparam logic [LANE_W-1:0] LANE_GZ = 3'd2;
    localparam logic [LANE_W-1:0] LANE_AX = 3'd3;
    localparam logic [LANE_W-1:0] LANE_AY = 3'd4;
    localparam logic [LANE_W-1:0] LANE_AZ = 3'd5;

    // opcodes
    localparam logic [1:0] OP_MEASURE    = 2'd0;
    localparam logic [1:0] OP_CAL_START  = 2'd1;
    localparam logic [1:0] OP_CAL_SAMPLE = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_READ_FAIL   = 2'd1;
    localparam logic [1:0] ST_CALIBRATING = 2'd2;
    localparam logic [1:0] ST_CAL_DONE    = 2'd3;

    // configuration register indexes and reset values
    localparam logic [1:0] REG_GYRO_SCALE  = 2'd0;
    localparam logic [1:0] REG_ACCEL_SCALE = 2'd1;
    localparam logic [1:0] REG_CAL_SAMPLES = 2'd2;
    localparam logic [SCALE_W-1:0] GYRO_SCALE_RST  = 24'd1023000;
    localparam logic [SCALE_W-1:0] ACCEL_SCALE_RST = 24'd4096;
    localparam logic [COUNT_W-1:0] CAL_SAMPLES_RST = 16'd200;

    // input request
    typedef struct packed {
        logic [1:0]              opcode;
        logic                    read_ok;
        logic signed [RAW_W-1:0] gyro_x_raw;
        logic signed [RAW_W-1:0] gyro_y_raw;
        logic signed [RAW_W-1:0] gyro_z_raw;
        logic signed [RAW_W-1:0] accel_x_raw;
        logic signed [RAW_W-1:0] accel_y_raw;
        logic signed [RAW_W-1:0] accel_z_raw;
    } t_in_item;

    // result request
    typedef struct packed {
        logic [1:0]              status;
        logic signed [OUT_W-1:0] gyro_x_out;
        logic signed [OUT_W-1:0] gyro_y_out;
        logic signed [OUT_W-1:0] gyro_z_out;
        logic signed [OUT_W-1:0] accel_x_out;
        logic signed [OUT_W-1:0] accel_y_out;
        logic signed [OUT_W-1:0] accel_z_out;
    } t_out_item;

    // control tag that travels with an operand pair through the multiplier
    typedef struct packed {
        logic              valid;
        logic              gyro;
        logic [LANE_W-1:0] lane;
    } t_mul_tag;

endpackage

// File: hw/rtl/imu_cal_div.sv
// bit-serial restoring divider, one quotient bit per cycle
module imu_cal_div #(
    parameter int DW = 40,
    parameter int VW = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [VW-1:0] i_divisor,
    output logic          o_done,
    output logic [DW-1:0] o_quotient
);
    localparam int CW = $clog2(DW + 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [DW-1:0] r_quo;
    logic [VW-1:0] r_rem;
    logic [VW-1:0] r_div;

    logic [VW:0]   rem_sh;
    logic          fits;
    logic [VW-1:0] n_rem;

    // one trial subtraction
    always_comb begin
        rem_sh = {r_rem, r_quo[DW-1]};
        fits   = rem_sh >= {1'b0, r_div};
        n_rem  = fits ? VW'(rem_sh - {1'b0, r_div}) : VW'(rem_sh);
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DW-2:0], fits};
            r_rem <= n_rem;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// File: hw/rtl/imu_cal_scale.sv
// shared multiplier with round-to-nearest shift and saturation to q16.16
module imu_cal_scale
    #(
    parameter int BIAS_FRAC_BITS = 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  imu_cal_pkg::t_mul_tag            i_tag,
    input  logic signed [BIAS_FRAC_BITS+17:0] i_a,
    input  logic [imu_cal_pkg::SCALE_W-1:0]  i_b,
    output imu_cal_pkg::t_mul_tag            o_tag,
    output logic signed [imu_cal_pkg::OUT_W-1:0] o_value
);
    import imu_cal_pkg::*;

    localparam int AW = BIAS_FRAC_BITS + 18;
    localparam int PW = AW + SCALE_W + 1;
    localparam int SH_ACCEL = SCALE_FRAC - OUT_FRAC;
    localparam int SH_GYRO  = SCALE_FRAC - OUT_FRAC + BIAS_FRAC_BITS;
    localparam logic signed [PW-1:0] HALF_ACCEL = PW'(1) << (SH_ACCEL - 1);
    localparam logic signed [PW-1:0] HALF_GYRO  = PW'(1) << (SH_GYRO - 1);
    localparam logic signed [PW-1:0] SAT_MAX = {{(PW-31){1'b0}}, {31{1'b1}}};
    localparam logic signed [PW-1:0] SAT_MIN = {{(PW-31){1'b1}}, {31{1'b0}}};

    t_mul_tag                r_tag1;
    t_mul_tag                r_tag2;
    logic signed [PW-1:0]    r_prod;
    logic signed [OUT_W-1:0] r_value;

    logic signed [PW-1:0]    n_prod;
    logic signed [PW-1:0]    rounded;
    logic signed [PW-1:0]    shifted;
    logic signed [OUT_W-1:0] n_value;

    // signed operand times unsigned scale
    assign n_prod = PW'(i_a) * $signed({{(PW-SCALE_W){1'b0}}, i_b});

    // round half up, drop fraction bits, clamp to 32 bits
    always_comb begin
        rounded = r_prod + (r_tag1.gyro ? HALF_GYRO : HALF_ACCEL);
        shifted = r_tag1.gyro ? (rounded >>> SH_GYRO) : (rounded >>> SH_ACCEL);
        if (shifted > SAT_MAX) begin
            n_value = SAT_MAX[OUT_W-1:0];
        end else if (shifted < SAT_MIN) begin
            n_value = SAT_MIN[OUT_W-1:0];
        end else begin
            n_value = shifted[OUT_W-1:0];
        end
    end

    // tag pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag1 <= '0;
            r_tag2 <= '0;
        end else begin
            r_tag1 <= i_tag;
            r_tag2 <= r_tag1;
        end
    end

    // product and result registers
    always_ff @(posedge i_clk) begin
        r_prod  <= n_prod;
        r_value <= n_value;
    end

    assign o_tag   = r_tag2;
    assign o_value = r_value;

endmodule

// File: hw/rtl/imu_bias_calibrate_and_scale.sv
// top level: gyro bias calibration by averaging and q16.16 scaling of six-axis samples
//
// One request is taken at a time; o_in_ready is high only while the sequencer is idle.
// Start calibration and calibration samples that do not finish the average, and measures
// whose read failed, go straight to the output state. A measure with a good read sends
// its six products one per cycle through a single shared multiplier with a two-stage
// round and clamp. The sample that completes calibration runs the bit-serial divider
// once per axis, one axis after another, and then goes to the output state.
// A finished result sits in the output register while the next request is accepted;
// if the previous result is still waiting there, the finish waits for it to leave.
module imu_bias_calibrate_and_scale
    #(
    parameter int BIAS_FRAC_BITS = imu_cal_pkg::BIAS_FRAC_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  imu_cal_pkg::t_in_item           i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output imu_cal_pkg::t_out_item          o_out_data,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [1:0]                      i_cfg_index,
    input  logic [imu_cal_pkg::SCALE_W-1:0] i_cfg_data
);
    import imu_cal_pkg::*;

    localparam int BW = BIAS_FRAC_BITS + 17;
    localparam int AW = BIAS_FRAC_BITS + 18;
    localparam int DW = SUM_W + BIAS_FRAC_BITS;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_DIV  = 4'b0010,
        S_MUL  = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

    t_state                  r_state;
    logic [SCALE_W-1:0]      r_gyro_scale;
    logic [SCALE_W-1:0]      r_accel_scale;
    logic [COUNT_W-1:0]      r_cal_samples;
    logic signed [BW-1:0]    r_bias [N_AXES];
    logic signed [SUM_W-1:0] r_sum  [N_AXES];
    logic [COUNT_W-1:0]      r_count;
    logic [1:0]              r_axis;
    logic                    r_div_busy;
    logic [LANE_W-1:0]       r_mul_cnt;
    logic                    r_out_valid;
    t_in_item                r_in;
    t_out_item               r_res;
    t_out_item               r_out;

    logic                    in_acc;
    logic                    out_free;
    logic [COUNT_W-1:0]      n_count;
    logic                    div_start;
    logic                    div_done;
    logic [DW-1:0]           div_quo;
    logic [SUM_W-1:0]        sum_mag;
    logic [BW-1:0]           quo_bits;
    logic signed [BW-1:0]    n_bias;
    t_mul_tag                mul_tag;
    t_mul_tag                rsp_tag;
    logic signed [RAW_W-1:0] mul_raw;
    logic signed [BW-1:0]    mul_bias;
    logic signed [AW-1:0]    mul_a;
    logic [SCALE_W-1:0]      mul_b;
    logic signed [OUT_W-1:0] rsp_value;

    assign in_acc      = i_in_valid && o_in_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign out_free    = !r_out_valid || i_out_ready;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign n_count     = r_count + 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gyro_scale  <= GYRO_SCALE_RST;
            r_accel_scale <= ACCEL_SCALE_RST;
            r_cal_samples <= CAL_SAMPLES_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_GYRO_SCALE:  r_gyro_scale  <= i_cfg_data;
                REG_ACCEL_SCALE: r_accel_scale <= i_cfg_data;
                REG_CAL_SAMPLES: r_cal_samples <= i_cfg_data[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // divider feed: magnitude of the sum with fraction bits appended
    always_comb begin
        sum_mag   = r_sum[r_axis][SUM_W-1] ? SUM_W'(-r_sum[r_axis]) : SUM_W'(r_sum[r_axis]);
        div_start = (r_state == S_DIV) && !r_div_busy;
        quo_bits  = div_quo[BW-1:0];
        n_bias    = r_sum[r_axis][SUM_W-1] ? -$signed(quo_bits) : $signed(quo_bits);
    end

    imu_cal_div #(
        .DW(DW),
        .VW(COUNT_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (DW'(sum_mag) << BIAS_FRAC_BITS),
        .i_divisor  (r_count),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    // operand select for the shared multiplier
    always_comb begin
        mul_tag.valid = (r_state == S_MUL) && (r_mul_cnt != LANE_W'(N_LANES));
        mul_tag.lane  = r_mul_cnt;
        mul_tag.gyro  = 1'b0;
        mul_bias      = '0;
        case (r_mul_cnt)
            LANE_GX: begin
                mul_raw = r_in.gyro_x_raw;  mul_bias = r_bias[0]; mul_tag.gyro = 1'b1;
            end
            LANE_GY: begin
                mul_raw = r_in.gyro_y_raw;  mul_bias = r_bias[1]; mul_tag.gyro = 1'b1;
            end
            LANE_GZ: begin
                mul_raw = r_in.gyro_z_raw;  mul_bias = r_bias[2]; mul_tag.gyro = 1'b1;
            end
            LANE_AX: mul_raw = r_in.accel_x_raw;
            LANE_AY: mul_raw = r_in.accel_y_raw;
            default: mul_raw = r_in.accel_z_raw;
        endcase
        mul_a = mul_tag.gyro ? ((AW'(mul_raw) <<< BIAS_FRAC_BITS) - AW'(mul_bias))
                             : AW'(mul_raw);
        mul_b = mul_tag.gyro ? r_gyro_scale : r_accel_scale;
    end

    imu_cal_scale #(
        .BIAS_FRAC_BITS(BIAS_FRAC_BITS)
    ) u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tag   (mul_tag),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_tag   (rsp_tag),
        .o_value (rsp_value)
    );

    // sequencer and calibration state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_axis      <= '0;
            r_div_busy  <= 1'b0;
            r_mul_cnt   <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < N_AXES; i++) begin
                r_bias[i] <= '0;
                r_sum[i]  <= '0;
            end
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_axis    <= '0;
                        r_mul_cnt <= '0;
                        unique case (i_in_data.opcode)
                            OP_CAL_START: begin
                                r_count <= '0;
                                for (int i = 0; i < N_AXES; i++) begin
                                    r_bias[i] <= '0;
                                    r_sum[i]  <= '0;
                                end
                                r_state <= S_OUT;
                            end
                            OP_CAL_SAMPLE: begin
                                r_state <= S_OUT;
                                if (r_count < r_cal_samples) begin
                                    r_count <= n_count;
                                    if (i_in_data.read_ok) begin
                                        r_sum[0] <= r_sum[0] + SUM_W'(i_in_data.gyro_x_raw);
                                        r_sum[1] <= r_sum[1] + SUM_W'(i_in_data.gyro_y_raw);
                                        r_sum[2] <= r_sum[2] + SUM_W'(i_in_data.gyro_z_raw);
                                    end
                                    if (n_count == r_cal_samples) begin
                                        r_state <= S_DIV;
                                    end
                                end
                            end
                            default: begin
                                r_state <= i_in_data.read_ok ? S_MUL : S_OUT;
                            end
                        endcase
                    end
                end
                S_DIV: begin
                    if (div_start) begin
                        r_div_busy <= 1'b1;
                    end else if (div_done) begin
                        r_div_busy     <= 1'b0;
                        r_bias[r_axis] <= n_bias;
                        if (r_axis == 2'(N_AXES - 1)) begin
                            r_state <= S_OUT;
                        end else begin
                            r_axis <= r_axis + 1'b1;
                        end
                    end
                end
                S_MUL: begin
                    if (mul_tag.valid) begin
                        r_mul_cnt <= r_mul_cnt + 1'b1;
                    end
                    if (rsp_tag.valid && rsp_tag.lane == LANE_AZ) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // request capture, working result and output register
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in  <= i_in_data;
            r_res <= '0;
            case (i_in_data.opcode)
                OP_CAL_START: r_res.status <= ST_CALIBRATING;
                OP_CAL_SAMPLE: begin
                    if (r_count >= r_cal_samples || n_count == r_cal_samples) begin
                        r_res.status <= ST_CAL_DONE;
                    end else begin
                        r_res.status <= ST_CALIBRATING;
                    end
                end
                default: r_res.status <= i_in_data.read_ok ? ST_OK : ST_READ_FAIL;
            endcase
        end else if (rsp_tag.valid) begin
            case (rsp_tag.lane)
                LANE_GX: r_res.gyro_x_out  <= rsp_value;
                LANE_GY: r_res.gyro_y_out  <= rsp_value;
                LANE_GZ: r_res.gyro_z_out  <= rsp_value;
                LANE_AX: r_res.accel_x_out <= rsp_value;
                LANE_AY: r_res.accel_y_out <= rsp_value;
                default: r_res.accel_z_out <= rsp_value;
            endcase
        end
        if (r_state == S_OUT && out_free) begin
            r_out <= r_res;
        end
    end

endmodule
